// ----- hw/rtl/dlr_pkg.sv -----
// Shared types, constants and codes for the IPv4 destination lookup redirect block.
package dlr_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Stream payload widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;

    // Request kinds carried on the input side
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Response kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Table request status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Frame layout
    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic [6:0]  COUNT_MAX      = 7'd127;
    localparam logic [6:0]  POS_TYPE_HI    = 7'd12;
    localparam logic [6:0]  POS_TYPE_LO    = 7'd13;
    localparam logic [6:0]  POS_VER_LEN    = 7'd14;
    localparam logic [6:0]  POS_DEST_0     = 7'd30;
    localparam logic [6:0]  POS_DEST_1     = 7'd31;
    localparam logic [6:0]  POS_DEST_2     = 7'd32;
    localparam logic [6:0]  POS_DEST_3     = 7'd33;
    localparam logic [6:0]  MIN_FRAME      = 7'd34;
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    // Search token that walks the cell chain
    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [31:0]      key;
        logic [IDX_W-1:0] pos;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [31:0]      hit_val;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } token_t;

    // Write command broadcast to the cells
    typedef struct packed {
        logic        set_entry;
        logic        set_value;
        logic        clear;
        logic [31:0] key;
        logic [31:0] value;
    } wr_cmd_t;

    // Frame check outcome for the byte being accepted
    typedef struct packed {
        logic        qualify;
        logic [31:0] dest;
    } frame_info_t;

endpackage

// ----- hw/rtl/dlr_cell.sv -----
// One table slot of the exact-match chain: stores an entry and updates the passing token.
module dlr_cell
    import dlr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  token_t  tok_in,
    output token_t  tok_out,
    input  logic    wr_sel,
    input  wr_cmd_t wr_cmd
);

    logic [31:0] key_reg;
    logic [31:0] value_reg;
    logic        valid_reg;
    token_t      tok_reg;
    token_t      tok_next;
    logic        match;

    // Compare the token against this slot and note the first hit and first free slot
    always_comb
    begin
        match    = valid_reg && (key_reg == tok_in.key);
        tok_next = tok_in;
        tok_next.pos = tok_in.pos + IDX_W'(1);
        if (!tok_in.hit && match)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = tok_in.pos;
            tok_next.hit_val = value_reg;
        end
        if (!tok_in.free_found && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = tok_in.pos;
        end
    end

    // Advance the token to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_sel)
        begin
            if (wr_cmd.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (wr_cmd.set_entry)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (wr_sel && wr_cmd.set_entry)
        begin
            key_reg <= wr_cmd.key;
        end
        if (wr_sel && (wr_cmd.set_entry || wr_cmd.set_value))
        begin
            value_reg <= wr_cmd.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hw/rtl/dlr_frame.sv -----
// Frame header capture: counts bytes, records type, version/length and destination.
module dlr_frame
    import dlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_en,
    input  logic [7:0]  byte_in,
    input  logic        last,
    output frame_info_t info
);

    logic [6:0]  byte_count_reg;
    logic [15:0] ether_kind_reg;
    logic [7:0]  version_length_reg;
    logic [31:0] dest_address_reg;

    logic [6:0]  count_upd;
    logic [15:0] kind_upd;
    logic [7:0]  vl_upd;
    logic [31:0] dest_upd;
    logic [7:0]  hdr_end;

    // Capture this byte into the header fields
    always_comb
    begin
        kind_upd = ether_kind_reg;
        vl_upd   = version_length_reg;
        dest_upd = dest_address_reg;
        case (byte_count_reg)
            POS_TYPE_HI: kind_upd[15:8]  = byte_in;
            POS_TYPE_LO: kind_upd[7:0]   = byte_in;
            POS_VER_LEN: vl_upd          = byte_in;
            POS_DEST_0:  dest_upd[31:24] = byte_in;
            POS_DEST_1:  dest_upd[23:16] = byte_in;
            POS_DEST_2:  dest_upd[15:8]  = byte_in;
            POS_DEST_3:  dest_upd[7:0]   = byte_in;
            default:     ;
        endcase
        count_upd = (byte_count_reg < COUNT_MAX) ? byte_count_reg + 7'd1 : byte_count_reg;
    end

    // Check the header once the frame ends
    always_comb
    begin
        hdr_end      = ETH_HDR_LEN + {2'b00, vl_upd[3:0], 2'b00};
        info.dest    = dest_upd;
        info.qualify = (count_upd >= MIN_FRAME) && (kind_upd == IPV4_ETHERTYPE) &&
                       (vl_upd[7:4] == IP_VERSION) && (vl_upd[3:0] >= IHL_MIN) &&
                       (hdr_end <= {1'b0, count_upd});
    end

    // Hold frame progress; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            ether_kind_reg     <= '0;
            version_length_reg <= '0;
            dest_address_reg   <= '0;
        end
        else if (byte_en)
        begin
            if (last)
            begin
                byte_count_reg     <= '0;
                ether_kind_reg     <= '0;
                version_length_reg <= '0;
                dest_address_reg   <= '0;
            end
            else
            begin
                byte_count_reg     <= count_upd;
                ether_kind_reg     <= kind_upd;
                version_length_reg <= vl_upd;
                dest_address_reg   <= dest_upd;
            end
        end
    end

endmodule

// ----- hw/rtl/ipv4_dest_lookup_redirect.sv -----
// Top level: stream ports, request control, cell chain and result register.
//
// Input channel s_axis: one transfer per request. tuser selects the kind
// (frame byte, table insert/update, table delete), tlast marks the final byte
// of a frame, tdata carries the frame byte, the key and the interface index.
// Output channel m_axis: one transfer per verdict or table status; tuser tells
// which, tdata carries redirect, interface index and status.
// Frame bytes that are not last give no output transfer.
// A last byte that fails the header checks loads a pass verdict at the edge
// that takes it, so it is offered in the next cycle; the next byte is taken
// once the output register can be reloaded.
// A last byte that passes the checks, an insert and a delete each send a
// search token through the chain of TABLE_ENTRIES cells, one cell per cycle;
// the finished token is held, its result is then loaded into the output
// register, and only after that is the next request taken, so the block
// handles one such request at a time.
// Reset clears all table valid bits, the frame progress and the control
// state; the block is ready as soon as reset is released.
// When the receiver stalls, the result stays in the output register and the
// input side stops taking transfers until that register can be reloaded.
module ipv4_dest_lookup_redirect
    import dlr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // packet_byte[7:0], key_address[39:8], target_index[71:40]
    input  logic [1:0]          s_axis_tuser,  // req_type[1:0]
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // redirect[0], out_index[32:1], status[34:33], zero pad
    output logic                m_axis_tuser   // resp_kind
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    token_t      hold_reg;
    logic [31:0] ins_val_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic        out_redir_reg;
    logic [31:0] out_index_reg;
    logic [1:0]  out_status_reg;

    logic        accept;
    logic        slot_free;
    logic        finish;
    logic        imm_res;
    logic [7:0]  in_byte;
    logic [31:0] in_key;
    logic [31:0] in_val;
    frame_info_t finfo;
    token_t      tok_launch;
    token_t      tok [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] tok_valid_vec;
    logic [TABLE_ENTRIES-1:0] wr_sel_vec;

    wr_cmd_t          wr_cmd;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             res_kind;
    logic             res_redir;
    logic [31:0]      res_index;
    logic [1:0]       res_status;

    // Unpack the input transfer
    assign in_byte = s_axis_tdata[7:0];
    assign in_key  = s_axis_tdata[39:8];
    assign in_val  = s_axis_tdata[71:40];

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = (state_reg == ST_DONE) && slot_free;

    // Frame header capture
    dlr_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (accept && (s_axis_tuser == REQ_PACKET)),
        .byte_in (in_byte),
        .last    (s_axis_tlast),
        .info    (finfo)
    );

    // Launch a search token or give an immediate pass verdict
    always_comb
    begin
        tok_launch = '0;
        imm_res    = 1'b0;
        if (accept)
        begin
            case (s_axis_tuser)
                REQ_PACKET:
                begin
                    if (s_axis_tlast)
                    begin
                        if (finfo.qualify)
                        begin
                            tok_launch.valid = 1'b1;
                            tok_launch.op    = REQ_PACKET;
                            tok_launch.key   = finfo.dest;
                        end
                        else
                        begin
                            imm_res = 1'b1;
                        end
                    end
                end
                REQ_INSERT, REQ_DELETE:
                begin
                    tok_launch.valid = 1'b1;
                    tok_launch.op    = s_axis_tuser;
                    tok_launch.key   = in_key;
                end
                default: ;
            endcase
        end
    end

    assign tok[0] = tok_launch;

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            assign wr_sel_vec[gi]    = wr_en && (wr_idx == IDX_W'(gi));
            assign tok_valid_vec[gi] = tok[gi+1].valid;
            dlr_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1]),
                .wr_sel  (wr_sel_vec[gi]),
                .wr_cmd  (wr_cmd)
            );
        end
    endgenerate

    // Turn the finished token into a result and a table write
    always_comb
    begin
        wr_cmd     = '0;
        wr_cmd.key   = hold_reg.key;
        wr_cmd.value = ins_val_reg;
        wr_en      = 1'b0;
        wr_idx     = hold_reg.hit_idx;
        res_kind   = KIND_STATUS;
        res_redir  = 1'b0;
        res_index  = '0;
        res_status = STATUS_OK;
        unique case (hold_reg.op)
            REQ_PACKET:
            begin
                res_kind  = KIND_VERDICT;
                res_redir = hold_reg.hit;
                res_index = hold_reg.hit ? hold_reg.hit_val : 32'd0;
            end
            REQ_INSERT:
            begin
                if (hold_reg.hit)
                begin
                    wr_cmd.set_value = 1'b1;
                    wr_en            = finish;
                end
                else if (hold_reg.free_found)
                begin
                    wr_cmd.set_entry = 1'b1;
                    wr_idx           = hold_reg.free_idx;
                    wr_en            = finish;
                end
                else
                begin
                    res_status = STATUS_FULL;
                end
            end
            REQ_DELETE:
            begin
                if (hold_reg.hit)
                begin
                    wr_cmd.clear = 1'b1;
                    wr_en        = finish;
                end
                else
                begin
                    res_status = STATUS_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    // Request sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (tok[0].valid) state_next = ST_WALK;
            ST_WALK: if (tok[TABLE_ENTRIES].valid) state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hold_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_WALK) && tok[TABLE_ENTRIES].valid)
            begin
                hold_reg <= tok[TABLE_ENTRIES];
            end
        end
    end

    // Hold the insert value while the token walks
    always_ff @(posedge clk)
    begin
        if (tok[0].valid)
        begin
            ins_val_reg <= in_val;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (imm_res || finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (imm_res)
        begin
            out_kind_reg   <= KIND_VERDICT;
            out_redir_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_status_reg <= STATUS_OK;
        end
        else if (finish)
        begin
            out_kind_reg   <= res_kind;
            out_redir_reg  <= res_redir;
            out_index_reg  <= res_index;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {5'b0, out_status_reg, out_index_reg, out_redir_reg};

    // At most one token in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one search token in the chain");

    // A walking request always has its token in the chain
    a_walk_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (|tok_valid_vec))
        else $error("walk state without a token in the chain");

    // A table write selects at most one cell
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_sel_vec))
        else $error("table write selects more than one cell");

    // A finished request always shows a result next cycle
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> m_axis_tvalid)
        else $error("finished request gave no result");

    // No input is taken while a request is in the chain
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (|tok_valid_vec) |-> !s_axis_tready)
        else $error("input taken while a token walks");

endmodule
